>>> sv/itchf_pkg.sv
package itchf_pkg;

    // Sizes of the filter and the framing
    localparam int LOC_SLOTS    = 4;
    localparam int TS_RANGES    = 2;
    localparam int PREFIX_BYTES = 2;
    localparam int TYPE_COUNT   = 22;

    localparam int TYPE_W   = 5;
    localparam int LEN_W    = 6;
    localparam int LOC_W    = 16;
    localparam int TS_W     = 48;
    localparam int PREFIX_W = 2;

    // APB register file
    localparam int CFG_ADDR_W = 6;
    localparam int CFG_DATA_W = 64;

    localparam logic [TYPE_COUNT-1:0] TYPE_MASK_RESET = {TYPE_COUNT{1'b1}};
    localparam logic [TS_W-1:0]       TS_MAX          = {TS_W{1'b1}};
    localparam logic [LEN_W-1:0]      UNKNOWN_LEN     = 6'd1;

    typedef enum logic [2:0] {
        REG_TYPE_MASK      = 3'd0,
        REG_LOC_COUNT      = 3'd1,
        REG_LOC_VALUES     = 3'd2,
        REG_TS_RANGE_COUNT = 3'd3,
        REG_TS_LOW_A       = 3'd4,
        REG_TS_HIGH_A      = 3'd5,
        REG_TS_LOW_B       = 3'd6,
        REG_TS_HIGH_B      = 3'd7
    } cfg_idx_t;

    // One framed message header, handed from the framer to the filter stage
    typedef struct packed {
        logic [TYPE_W-1:0] type_index;
        logic              unknown_type;
        logic [LOC_W-1:0]  locate;
        logic [TS_W-1:0]   timestamp;
        logic [LEN_W-1:0]  msg_length;
    } msg_t;

    typedef struct packed {
        logic              known;
        logic [TYPE_W-1:0] idx;
        logic [LEN_W-1:0]  len;
    } type_info_t;

    // ITCH 5.0 type byte to index and message length
    function automatic type_info_t type_lookup(input logic [7:0] code);
        type_info_t info;
        info.known = 1'b1;
        info.idx   = '0;
        info.len   = UNKNOWN_LEN;
        unique case (code)
            8'h53: begin info.idx = 5'd0;  info.len = 6'd12; end // S
            8'h52: begin info.idx = 5'd1;  info.len = 6'd39; end // R
            8'h48: begin info.idx = 5'd2;  info.len = 6'd25; end // H
            8'h59: begin info.idx = 5'd3;  info.len = 6'd20; end // Y
            8'h4C: begin info.idx = 5'd4;  info.len = 6'd26; end // L
            8'h56: begin info.idx = 5'd5;  info.len = 6'd35; end // V
            8'h57: begin info.idx = 5'd6;  info.len = 6'd12; end // W
            8'h4B: begin info.idx = 5'd7;  info.len = 6'd28; end // K
            8'h4A: begin info.idx = 5'd8;  info.len = 6'd35; end // J
            8'h68: begin info.idx = 5'd9;  info.len = 6'd21; end // h
            8'h41: begin info.idx = 5'd10; info.len = 6'd36; end // A
            8'h46: begin info.idx = 5'd11; info.len = 6'd40; end // F
            8'h45: begin info.idx = 5'd12; info.len = 6'd31; end // E
            8'h43: begin info.idx = 5'd13; info.len = 6'd36; end // C
            8'h58: begin info.idx = 5'd14; info.len = 6'd23; end // X
            8'h44: begin info.idx = 5'd15; info.len = 6'd19; end // D
            8'h55: begin info.idx = 5'd16; info.len = 6'd35; end // U
            8'h50: begin info.idx = 5'd17; info.len = 6'd44; end // P
            8'h51: begin info.idx = 5'd18; info.len = 6'd40; end // Q
            8'h42: begin info.idx = 5'd19; info.len = 6'd19; end // B
            8'h49: begin info.idx = 5'd20; info.len = 6'd50; end // I
            8'h4E: begin info.idx = 5'd21; info.len = 6'd20; end // N
            default: info.known = 1'b0;
        endcase
        return info;
    endfunction

endpackage

>>> sv/itchf_if.sv
// Byte stream channel
interface itchf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

// Message result channel
interface itchf_msg_if;
    logic        valid;
    logic        ready;
    logic [4:0]  type_index;
    logic        unknown_type;
    logic [15:0] locate;
    logic [47:0] timestamp;
    logic [5:0]  msg_length;
    logic        keep;

    modport source (output valid, output type_index, output unknown_type, output locate,
                    output timestamp, output msg_length, output keep, input ready);
    modport sink   (input valid, input type_index, input unknown_type, input locate,
                    input timestamp, input msg_length, input keep, output ready);
endinterface

>>> sv/itchf_framer.sv
module itchf_framer (
    input  logic                clk,
    input  logic                rst_n,
    itchf_byte_if.sink          byte_in,
    output logic                msg_valid,
    output itchf_pkg::msg_t     msg,
    input  logic                msg_take
);
    import itchf_pkg::*;

    logic [PREFIX_W-1:0] prefix_left_reg, prefix_left_next;
    logic [LEN_W-1:0]    byte_offset_reg, byte_offset_next;
    logic [LEN_W-1:0]    cur_length_reg, cur_length_next;
    logic [TYPE_W-1:0]   cur_type_reg, cur_type_next;
    logic [LOC_W-1:0]    loc_acc_reg, loc_acc_next;
    logic [TS_W-1:0]     ts_acc_reg, ts_acc_next;
    logic                msg_valid_reg, msg_valid_next;
    msg_t                msg_reg, msg_next;

    logic       accept;
    logic       emit;
    type_info_t info;

    assign byte_in.ready = !msg_valid_reg || msg_take;
    assign accept        = byte_in.valid && byte_in.ready;
    assign info          = type_lookup(byte_in.data_byte);

    // Framing state machine for one byte
    always_comb
    begin
        prefix_left_next = prefix_left_reg;
        byte_offset_next = byte_offset_reg;
        cur_length_next  = cur_length_reg;
        cur_type_next    = cur_type_reg;
        loc_acc_next     = loc_acc_reg;
        ts_acc_next      = ts_acc_reg;
        emit             = 1'b0;
        msg_next         = msg_reg;

        if (accept)
        begin
            if (prefix_left_reg != '0)
            begin
                prefix_left_next = prefix_left_reg - 1'b1;
            end
            else if (byte_offset_reg == '0)
            begin
                if (info.known)
                begin
                    cur_type_next    = info.idx;
                    cur_length_next  = info.len;
                    byte_offset_next = LEN_W'(1);
                end
                else
                begin
                    // unknown type: one-byte message, reported at once
                    emit                  = 1'b1;
                    msg_next.type_index   = '0;
                    msg_next.unknown_type = 1'b1;
                    msg_next.locate       = '0;
                    msg_next.timestamp    = '0;
                    msg_next.msg_length   = UNKNOWN_LEN;
                end
            end
            else
            begin
                if (byte_offset_reg == LEN_W'(1) || byte_offset_reg == LEN_W'(2))
                    loc_acc_next = {loc_acc_reg[LOC_W-9:0], byte_in.data_byte};
                if (byte_offset_reg >= LEN_W'(5) && byte_offset_reg <= LEN_W'(10))
                    ts_acc_next = {ts_acc_reg[TS_W-9:0], byte_in.data_byte};

                if (({1'b0, byte_offset_reg} + 7'd1) < {1'b0, cur_length_reg})
                begin
                    byte_offset_next = byte_offset_reg + 1'b1;
                end
                else
                begin
                    emit                  = 1'b1;
                    msg_next.type_index   = cur_type_reg;
                    msg_next.unknown_type = 1'b0;
                    msg_next.locate       = loc_acc_next;
                    msg_next.timestamp    = ts_acc_next;
                    msg_next.msg_length   = cur_length_reg;
                end
            end

            // restart framing after the last byte
            if (emit)
            begin
                prefix_left_next = PREFIX_W'(PREFIX_BYTES);
                byte_offset_next = '0;
                cur_length_next  = '0;
                cur_type_next    = '0;
                loc_acc_next     = '0;
                ts_acc_next      = '0;
            end
        end
    end

    // Output stage handshake
    always_comb
    begin
        if (emit)
            msg_valid_next = 1'b1;
        else if (msg_take)
            msg_valid_next = 1'b0;
        else
            msg_valid_next = msg_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_left_reg <= PREFIX_W'(PREFIX_BYTES);
            byte_offset_reg <= '0;
            cur_length_reg  <= '0;
            cur_type_reg    <= '0;
            loc_acc_reg     <= '0;
            ts_acc_reg      <= '0;
            msg_valid_reg   <= 1'b0;
        end
        else
        begin
            prefix_left_reg <= prefix_left_next;
            byte_offset_reg <= byte_offset_next;
            cur_length_reg  <= cur_length_next;
            cur_type_reg    <= cur_type_next;
            loc_acc_reg     <= loc_acc_next;
            ts_acc_reg      <= ts_acc_next;
            msg_valid_reg   <= msg_valid_next;
        end
    end

    // Header payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (emit)
            msg_reg <= msg_next;
    end

    assign msg_valid = msg_valid_reg;
    assign msg       = msg_reg;

endmodule

>>> sv/itch_message_framer_filter_unit.sv
// ITCH 5.0 message framer and filter. Takes a framed ITCH 5.0 file one byte per
// transfer, at up to one byte every cycle, skipping the two length-prefix bytes
// ahead of each message. On the last byte of a message it reports the type index,
// locate, timestamp, length and a keep flag through the framer register, then the
// filter register; both stages hold their contents under back-pressure while still
// taking bytes as long as they have room. Filters (type mask, up to four locates,
// up to two inclusive timestamp ranges) are set through a 64-bit APB port,
// registers at 8-byte strides, and should be written only while no message is in
// flight.
module itch_message_framer_filter_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    itchf_byte_if.sink                        byte_in,
    itchf_msg_if.source                       msg_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [itchf_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [itchf_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [itchf_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                              pready
);
    import itchf_pkg::*;

    // Configuration registers
    logic [TYPE_COUNT-1:0]      type_mask_reg;
    logic [2:0]                 loc_count_reg;
    logic [LOC_SLOTS*LOC_W-1:0] loc_values_reg;
    logic [1:0]                 ts_range_count_reg;
    logic [TS_W-1:0]            ts_low_a_reg, ts_high_a_reg, ts_low_b_reg, ts_high_b_reg;

    logic     cfg_write;
    cfg_idx_t cfg_idx;

    logic   msg_valid;
    msg_t   msg;
    logic   msg_take;

    logic   out_valid_reg, out_valid_next;
    msg_t   out_msg_reg;
    logic   out_keep_reg;

    logic   keep;
    logic   type_pass, loc_pass, ts_pass;
    logic   loc_hit;
    logic [2:0] loc_n;
    logic [1:0] ts_n;
    logic   in_a, in_b;

    itchf_framer u_framer (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_in   (byte_in),
        .msg_valid (msg_valid),
        .msg       (msg),
        .msg_take  (msg_take)
    );

    // APB register file
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = cfg_idx_t'(paddr[CFG_ADDR_W-1:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            type_mask_reg      <= TYPE_MASK_RESET;
            loc_count_reg      <= '0;
            loc_values_reg     <= '0;
            ts_range_count_reg <= '0;
            ts_low_a_reg       <= '0;
            ts_high_a_reg      <= TS_MAX;
            ts_low_b_reg       <= '0;
            ts_high_b_reg      <= TS_MAX;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_TYPE_MASK:      type_mask_reg      <= pwdata[TYPE_COUNT-1:0];
                REG_LOC_COUNT:      loc_count_reg      <= pwdata[2:0];
                REG_LOC_VALUES:     loc_values_reg     <= pwdata[LOC_SLOTS*LOC_W-1:0];
                REG_TS_RANGE_COUNT: ts_range_count_reg <= pwdata[1:0];
                REG_TS_LOW_A:       ts_low_a_reg       <= pwdata[TS_W-1:0];
                REG_TS_HIGH_A:      ts_high_a_reg      <= pwdata[TS_W-1:0];
                REG_TS_LOW_B:       ts_low_b_reg       <= pwdata[TS_W-1:0];
                REG_TS_HIGH_B:      ts_high_b_reg      <= pwdata[TS_W-1:0];
                default: ;
            endcase
        end
    end

    // Read-back
    always_comb
    begin
        prdata = '0;
        unique case (cfg_idx)
            REG_TYPE_MASK:      prdata = CFG_DATA_W'(type_mask_reg);
            REG_LOC_COUNT:      prdata = CFG_DATA_W'(loc_count_reg);
            REG_LOC_VALUES:     prdata = CFG_DATA_W'(loc_values_reg);
            REG_TS_RANGE_COUNT: prdata = CFG_DATA_W'(ts_range_count_reg);
            REG_TS_LOW_A:       prdata = CFG_DATA_W'(ts_low_a_reg);
            REG_TS_HIGH_A:      prdata = CFG_DATA_W'(ts_high_a_reg);
            REG_TS_LOW_B:       prdata = CFG_DATA_W'(ts_low_b_reg);
            REG_TS_HIGH_B:      prdata = CFG_DATA_W'(ts_high_b_reg);
            default: ;
        endcase
    end

    // Filter decision on the framed header
    assign loc_n = (loc_count_reg > 3'(LOC_SLOTS)) ? 3'(LOC_SLOTS) : loc_count_reg;
    assign ts_n  = (ts_range_count_reg > 2'(TS_RANGES)) ? 2'(TS_RANGES) : ts_range_count_reg;

    always_comb
    begin
        loc_hit = 1'b0;
        for (int i = 0; i < LOC_SLOTS; i++)
        begin
            if (3'(i) < loc_n && loc_values_reg[i*LOC_W +: LOC_W] == msg.locate)
                loc_hit = 1'b1;
        end
    end

    assign type_pass = (msg.type_index < TYPE_W'(TYPE_COUNT)) && type_mask_reg[msg.type_index];
    assign loc_pass  = (loc_n == '0) || loc_hit;
    assign in_a      = (msg.timestamp >= ts_low_a_reg) && (msg.timestamp <= ts_high_a_reg);
    assign in_b      = (TS_RANGES >= 2) && (ts_n >= 2'd2)
                       && (msg.timestamp >= ts_low_b_reg) && (msg.timestamp <= ts_high_b_reg);
    assign ts_pass   = (ts_n == '0) || in_a || in_b;
    assign keep      = !msg.unknown_type && type_pass && loc_pass && ts_pass;

    // Result register
    assign msg_take = !out_valid_reg || msg_out.ready;

    always_comb
    begin
        if (msg_take)
            out_valid_next = msg_valid;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (msg_take && msg_valid)
        begin
            out_msg_reg  <= msg;
            out_keep_reg <= keep;
        end
    end

    assign msg_out.valid        = out_valid_reg;
    assign msg_out.type_index   = out_msg_reg.type_index;
    assign msg_out.unknown_type = out_msg_reg.unknown_type;
    assign msg_out.locate       = out_msg_reg.locate;
    assign msg_out.timestamp    = out_msg_reg.timestamp;
    assign msg_out.msg_length   = out_msg_reg.msg_length;
    assign msg_out.keep         = out_keep_reg;

endmodule

>>> sv/itchf_checker.sv
module itchf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [4:0]  type_index,
    input logic        unknown_type,
    input logic [15:0] locate,
    input logic [47:0] timestamp,
    input logic [5:0]  msg_length,
    input logic        keep
);

    // A stalled result stays offered
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its payload
    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable({type_index, unknown_type, locate,
                                             timestamp, msg_length, keep}))
        else $error("result payload changed while stalled");

    // Unknown type: one byte, empty header, never kept
    a_unknown: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && unknown_type |-> msg_length == 6'd1 && !keep && locate == 16'd0
                                      && timestamp == 48'd0 && type_index == 5'd0)
        else $error("bad unknown-type result");

    // Known types are at least a system-event message long
    a_known_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !unknown_type |-> msg_length >= 6'd12 && msg_length <= 6'd50)
        else $error("known message with impossible length");

    a_type_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> type_index <= 5'd21)
        else $error("type index out of range");

endmodule

bind itch_message_framer_filter_unit itchf_checker u_itchf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (msg_out.valid),
    .out_ready    (msg_out.ready),
    .type_index   (msg_out.type_index),
    .unknown_type (msg_out.unknown_type),
    .locate       (msg_out.locate),
    .timestamp    (msg_out.timestamp),
    .msg_length   (msg_out.msg_length),
    .keep         (msg_out.keep)
);

>>> verif/tb_itch_message_framer_filter_unit.sv
import itchf_pkg::*;

// One message header as reported on the result channel
typedef struct packed {
    logic [4:0]  type_index;
    logic        unknown_type;
    logic [15:0] locate;
    logic [47:0] timestamp;
    logic [5:0]  msg_length;
    logic        keep;
} itch_result_t;

// Tracks the byte stream, frames messages and holds the headers still owed by the block
class itch_msg_tracker;
    // filter settings as last written
    logic [21:0] type_mask;
    logic [2:0]  loc_count;
    logic [63:0] loc_values;
    logic [1:0]  ts_range_count;
    logic [47:0] ts_low_a;
    logic [47:0] ts_high_a;
    logic [47:0] ts_low_b;
    logic [47:0] ts_high_b;

    // framing state
    int unsigned prefix_left;
    int unsigned byte_offset;
    int unsigned cur_length;
    logic [4:0]  cur_type;
    logic        cur_unknown;
    logic [15:0] loc_acc;
    logic [47:0] ts_acc;

    // type bytes in index order, with their message lengths
    string       codes;
    int unsigned lengths[22];

    itch_result_t due_msgs[$];
    int           errors;

    function new();
        codes = "SRHYLVWKJhAFECXDUPQBIN";
        lengths = '{12, 39, 25, 20, 26, 35, 12, 28, 35, 21, 36,
                    40, 31, 36, 23, 19, 35, 44, 40, 19, 50, 20};
        type_mask      = '1;
        loc_count      = '0;
        loc_values     = '0;
        ts_range_count = '0;
        ts_low_a       = '0;
        ts_high_a      = '1;
        ts_low_b       = '0;
        ts_high_b      = '1;
        errors         = 0;
        restart_frame();
    endfunction

    function void restart_frame();
        prefix_left = PREFIX_BYTES;
        byte_offset = 0;
        cur_length  = 0;
        cur_type    = '0;
        cur_unknown = 1'b0;
        loc_acc     = '0;
        ts_acc      = '0;
    endfunction

    function void set_reg(input cfg_idx_t r, input logic [63:0] v);
        unique case (r)
            REG_TYPE_MASK:      type_mask      = v[21:0];
            REG_LOC_COUNT:      loc_count      = v[2:0];
            REG_LOC_VALUES:     loc_values     = v;
            REG_TS_RANGE_COUNT: ts_range_count = v[1:0];
            REG_TS_LOW_A:       ts_low_a       = v[47:0];
            REG_TS_HIGH_A:      ts_high_a      = v[47:0];
            REG_TS_LOW_B:       ts_low_b       = v[47:0];
            REG_TS_HIGH_B:      ts_high_b      = v[47:0];
            default:            ;
        endcase
    endfunction

    function bit find_code(input logic [7:0] b, output int idx);
        idx = 0;
        for (int i = 0; i < TYPE_COUNT; i++)
        begin
            if (8'(codes[i]) == b)
            begin
                idx = i;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function int msg_length_of(input logic [7:0] b);
        int idx;
        return find_code(b, idx) ? lengths[idx] : 1;
    endfunction

    // counts above the slot number saturate; zero slots lets everything through
    function bit locate_ok();
        int n;
        n = (loc_count > LOC_SLOTS) ? LOC_SLOTS : loc_count;
        if (n == 0)
            return 1'b1;
        for (int i = 0; i < n; i++)
        begin
            if (loc_values[16*i +: 16] == loc_acc)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // inverted bounds match nothing, which the plain compare gives for free
    function bit stamp_ok();
        int n;
        n = (ts_range_count > TS_RANGES) ? TS_RANGES : ts_range_count;
        if (n == 0)
            return 1'b1;
        if (ts_acc >= ts_low_a && ts_acc <= ts_high_a)
            return 1'b1;
        if (n >= 2 && ts_acc >= ts_low_b && ts_acc <= ts_high_b)
            return 1'b1;
        return 1'b0;
    endfunction

    // one accepted byte transfer
    function void take_byte(input logic [7:0] b);
        int           idx;
        itch_result_t r;
        if (prefix_left > 0)
        begin
            prefix_left--;
            return;
        end
        if (byte_offset == 0)
        begin
            cur_unknown = !find_code(b, idx);
            cur_type    = cur_unknown ? 5'd0 : 5'(idx);
            cur_length  = cur_unknown ? 1 : lengths[idx];
        end
        else
        begin
            if (byte_offset <= 2)
                loc_acc = {loc_acc[7:0], b};
            if (byte_offset >= 5 && byte_offset <= 10)
                ts_acc = {ts_acc[39:0], b};
        end
        if (byte_offset + 1 < cur_length)
        begin
            byte_offset++;
            return;
        end
        r.type_index   = cur_type;
        r.unknown_type = cur_unknown;
        r.locate       = loc_acc;
        r.timestamp    = ts_acc;
        r.msg_length   = 6'(cur_length);
        r.keep         = !cur_unknown && type_mask[cur_type] && locate_ok() && stamp_ok();
        due_msgs.push_back(r);
        restart_frame();
    endfunction

    function void field_cmp(input string name, input logic [63:0] want, input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    // one accepted result transfer
    function void check_msg(input itch_result_t got);
        itch_result_t want;
        if (due_msgs.size() == 0)
        begin
            $display("%0t: result with none expected, expected nothing, got %h", $time, got);
            errors++;
            return;
        end
        want = due_msgs.pop_front();
        field_cmp("type_index", want.type_index, got.type_index);
        field_cmp("unknown_type", want.unknown_type, got.unknown_type);
        field_cmp("locate", want.locate, got.locate);
        field_cmp("timestamp", want.timestamp, got.timestamp);
        field_cmp("msg_length", want.msg_length, got.msg_length);
        field_cmp("keep", want.keep, got.keep);
    endfunction
endclass

module tb_itch_message_framer_filter_unit;

    localparam int          ITEM_TARGET = 1400;
    localparam int          HOLD_CYCLES = 300;
    localparam logic [7:0]  CODE_S      = "S";
    localparam logic [7:0]  CODE_NONE   = 8'h00;
    localparam logic [7:0]  CODE_HIGH   = 8'hFF;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    itchf_byte_if byte_ch();
    itchf_msg_if  msg_ch();

    itch_msg_tracker tracker = new();
    int unsigned     bytes_sent = 0;
    bit              sender_calm = 1'b0;
    bit              hold_req = 1'b0;

    itch_message_framer_filter_unit uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_in (byte_ch),
        .msg_out (msg_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watch both channels; byte first so a header is noted before it can be due
    always @(posedge clk)
    begin
        itch_result_t got;
        if (rst_n)
        begin
            if (byte_ch.valid && byte_ch.ready)
                tracker.take_byte(byte_ch.data_byte);
            if (msg_ch.valid && msg_ch.ready)
            begin
                got.type_index   = msg_ch.type_index;
                got.unknown_type = msg_ch.unknown_type;
                got.locate       = msg_ch.locate;
                got.timestamp    = msg_ch.timestamp;
                got.msg_length   = msg_ch.msg_length;
                got.keep         = msg_ch.keep;
                tracker.check_msg(got);
            end
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result side back-pressure, with calm stretches and one long hold-off on request
    initial
    begin
        int stall;
        int window;
        bit calm;
        stall  = 0;
        window = 0;
        calm   = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                msg_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                if (window == 0)
                begin
                    calm   = ($urandom_range(0, 2) == 0);
                    window = $urandom_range(20, 200);
                end
                window--;
                if (stall > 0)
                begin
                    msg_ch.ready <= 1'b0;
                    stall--;
                end
                else
                begin
                    msg_ch.ready <= 1'b1;
                    if (!calm && $urandom_range(0, 3) == 0)
                        stall = gap_len();
                end
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = (!sender_calm && $urandom_range(0, 3) == 0) ? gap_len() : 0;
        if (gap > 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= b;
        @(posedge clk);
        while (!byte_ch.ready) @(posedge clk);
        bytes_sent++;
    endtask

    // prefix, type byte, then the body with locate and timestamp in place
    task automatic send_msg(input logic [7:0] code, input logic [15:0] loc,
                            input logic [47:0] ts);
        int         len;
        logic [7:0] b;
        len = tracker.msg_length_of(code);
        for (int p = 0; p < PREFIX_BYTES; p++)
            send_byte(8'($urandom));
        send_byte(code);
        for (int k = 1; k < len; k++)
        begin
            b = 8'($urandom);
            if (k == 1)
                b = loc[15:8];
            else if (k == 2)
                b = loc[7:0];
            else if (k >= 5 && k <= 10)
                b = ts[8*(10-k) +: 8];
            send_byte(b);
        end
    endtask

    task automatic apb_write(input cfg_idx_t r, input logic [63:0] v);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 3'b000};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        tracker.set_reg(r, v);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // stop offering, let every owed header out, then allow for the pipeline
    task automatic wait_drained();
        byte_ch.valid <= 1'b0;
        @(posedge clk);
        while (tracker.due_msgs.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic pick_range(output logic [47:0] lo, output logic [47:0] hi);
        lo = 48'({$urandom, $urandom});
        case ($urandom_range(0, 4))
            0:
            begin
                lo = '0;
                hi = '1;
            end
            1:       hi = lo + $urandom_range(0, 1000);
            2:       hi = lo - $urandom_range(1, 1000);
            3:       hi = lo;
            default: hi = 48'({$urandom, $urandom});
        endcase
    endtask

    // mode 1: every register at its top, mode 2: all zero, else random with junk in unused bits
    task automatic configure(input int mode);
        logic [63:0] v[8];
        logic [47:0] lo;
        logic [47:0] hi;
        if (mode == 1)
        begin
            foreach (v[i])
                v[i] = '1;
        end
        else if (mode == 2)
        begin
            foreach (v[i])
                v[i] = '0;
        end
        else
        begin
            case ($urandom_range(0, 3))
                0:       v[REG_TYPE_MASK] = '1;
                1:       v[REG_TYPE_MASK] = '0;
                2:       v[REG_TYPE_MASK] = 64'd1 << $urandom_range(0, TYPE_COUNT - 1);
                default: v[REG_TYPE_MASK] = {$urandom, $urandom};
            endcase
            v[REG_LOC_COUNT]      = {$urandom, $urandom};
            v[REG_LOC_COUNT][2:0] = 3'($urandom_range(0, 7));
            case ($urandom_range(0, 3))
                0:       v[REG_LOC_VALUES] = '0;
                1:       v[REG_LOC_VALUES] = '1;
                default: v[REG_LOC_VALUES] = {$urandom, $urandom};
            endcase
            v[REG_TS_RANGE_COUNT]      = {$urandom, $urandom};
            v[REG_TS_RANGE_COUNT][1:0] = 2'($urandom_range(0, 3));
            pick_range(lo, hi);
            v[REG_TS_LOW_A]  = {16'($urandom), lo};
            v[REG_TS_HIGH_A] = {16'($urandom), hi};
            pick_range(lo, hi);
            v[REG_TS_LOW_B]  = {16'($urandom), lo};
            v[REG_TS_HIGH_B] = {16'($urandom), hi};
        end
        for (int i = 0; i < 8; i++)
            apb_write(cfg_idx_t'(i), v[i]);
    endtask

    function automatic logic [7:0] pick_code();
        if ($urandom_range(0, 4) == 0)
            return 8'($urandom);
        return 8'(tracker.codes[$urandom_range(0, TYPE_COUNT - 1)]);
    endfunction

    // locates lean towards the configured slots so the filter both hits and misses
    function automatic logic [15:0] pick_loc();
        int slot;
        slot = $urandom_range(0, LOC_SLOTS - 1);
        case ($urandom_range(0, 5)) inside
            0:       return '0;
            1:       return '1;
            [2:3]:   return tracker.loc_values[16*slot +: 16];
            default: return 16'($urandom);
        endcase
    endfunction

    // timestamps on, just off and inside the range bounds
    function automatic logic [47:0] pick_ts();
        logic [47:0] r;
        logic [47:0] lo;
        logic [47:0] span;
        r = 48'({$urandom, $urandom});
        case ($urandom_range(0, 11))
            0:  return tracker.ts_low_a;
            1:  return tracker.ts_high_a;
            2:  return tracker.ts_low_a - 1;
            3:  return tracker.ts_high_a + 1;
            4:  return tracker.ts_low_b;
            5:  return tracker.ts_high_b;
            6:  return tracker.ts_low_b - 1;
            7:  return tracker.ts_high_b + 1;
            8:  return '0;
            9:  return '1;
            10:
            begin
                lo   = $urandom_range(0, 1) ? tracker.ts_low_a : tracker.ts_low_b;
                span = ($urandom_range(0, 1) ? tracker.ts_high_a : tracker.ts_high_b) - lo;
                if (span == '1)
                    return r;
                return lo + r % (span + 48'd1);
            end
            default: return r;
        endcase
    endfunction

    // main stimulus
    initial
    begin
        int phase;
        byte_ch.valid     <= 1'b0;
        byte_ch.data_byte <= '0;
        msg_ch.ready      <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        rst_n             <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: unknown type bytes at both ends, then a short message at full scale
        send_msg(CODE_NONE, '0, '0);
        send_msg(CODE_HIGH, '0, '0);
        send_msg(CODE_S, '1, '1);
        wait_drained();

        phase = 0;
        while (bytes_sent < ITEM_TARGET)
        begin
            sender_calm = ($urandom_range(0, 3) == 0);
            configure((phase == 0) ? 1 : (phase == 1) ? 2 : 0);
            if (phase == 2)
            begin
                // long result hold-off against a steady stream of short messages
                sender_calm = 1'b1;
                hold_req    = 1'b1;
                repeat (40)
                    send_msg(($urandom_range(0, 3) == 0) ? CODE_S : CODE_NONE,
                             pick_loc(), pick_ts());
            end
            else
            begin
                repeat ($urandom_range(3, 10))
                    send_msg(pick_code(), pick_loc(), pick_ts());
            end
            wait_drained();
            phase++;
        end

        if (tracker.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // overall time limit
    initial
    begin
        #4000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

>>> filelist.f
sv/itchf_pkg.sv
sv/itchf_if.sv
sv/itchf_framer.sv
sv/itch_message_framer_filter_unit.sv
sv/itchf_checker.sv
verif/tb_itch_message_framer_filter_unit.sv
